>>> src/tlvsp_pkg.sv
`default_nettype none

package tlvsp_pkg;

    // Record header: one type byte and a four-byte little-endian length.
    localparam int unsigned HDR_BYTES = 5;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_STRICT_MODE      = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_FANOUT       = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_SAGA_STEPS   = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_GROUP_LENGTH = 8'd3;

    localparam logic [31:0] RST_MAX_FANOUT       = 32'd1024;
    localparam logic [31:0] RST_MAX_SAGA_STEPS   = 32'd256;
    localparam logic [31:0] RST_MAX_GROUP_LENGTH = 32'd256;

    // Status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_TRUNC   = 3'd1;
    localparam logic [2:0] ST_LEN     = 3'd2;
    localparam logic [2:0] ST_LIMIT   = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;

    // Record types with special checks.
    localparam logic [7:0] T_FANOUT    = 8'd1;
    localparam logic [7:0] T_SAGA_STEP = 8'd5;
    localparam logic [7:0] T_GROUP     = 8'd9;
    localparam logic [7:0] T_LAST      = 8'd12;

    typedef struct packed {
        logic        strict_mode;
        logic [31:0] max_fanout;
        logic [31:0] max_saga_steps;
        logic [31:0] max_group_length;
    } cfg_t;

    typedef struct packed {
        logic        record_valid;
        logic [7:0]  record_type;
        logic [63:0] record_value;
        logic [31:0] record_length;
        logic [31:0] value_offset;
        logic [2:0]  status;
        logic        section_end;
    } result_t;

    // Required value length of a known type; type 9 has no fixed length and gets zero.
    function automatic logic [3:0] need_len(input logic [7:0] t);
        logic [3:0] n;
        unique case (t)
            8'd2, 8'd6, 8'd10, 8'd11:       n = 4'd1;
            8'd1, 8'd3, 8'd5, 8'd7, 8'd12:  n = 4'd4;
            8'd4, 8'd8:                     n = 4'd8;
            default:                        n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

>>> src/tlvsp_cfg_regs.sv
`default_nettype none

module tlvsp_cfg_regs (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [tlvsp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [31:0]                          cfg_data,
    output tlvsp_pkg::cfg_t                           cfg
);
    import tlvsp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_STRICT_MODE:      cfg_next.strict_mode      = cfg_data[0];
                REG_MAX_FANOUT:       cfg_next.max_fanout       = cfg_data;
                REG_MAX_SAGA_STEPS:   cfg_next.max_saga_steps   = cfg_data;
                REG_MAX_GROUP_LENGTH: cfg_next.max_group_length = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.strict_mode      <= 1'b0;
            cfg_reg.max_fanout       <= RST_MAX_FANOUT;
            cfg_reg.max_saga_steps   <= RST_MAX_SAGA_STEPS;
            cfg_reg.max_group_length <= RST_MAX_GROUP_LENGTH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> src/tlvsp_core.sv
`default_nettype none

module tlvsp_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [7:0]        data_byte,
    input  wire logic              last_byte,
    input  wire tlvsp_pkg::cfg_t   cfg,
    output logic                   emit,
    output tlvsp_pkg::result_t     result
);
    import tlvsp_pkg::*;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_VALUE  = 2'd1;
    localparam logic [1:0] PH_SKIP   = 2'd2;

    logic [1:0]  phase_reg,         phase_next;
    logic [2:0]  header_count_reg,  header_count_next;
    logic [7:0]  type_reg,          type_next;
    logic [31:0] length_reg,        length_next;
    logic [31:0] value_count_reg,   value_count_next;
    logic [63:0] value_accum_reg,   value_accum_next;
    logic [31:0] byte_position_reg, byte_position_next;
    logic [2:0]  error_code_reg,    error_code_next;

    logic        done;
    logic        known;
    logic [2:0]  judge_st;
    logic [31:0] pos_inc;
    logic [31:0] value_count_inc;
    logic [1:0]  hdr_sel;

    always_comb
    begin
        phase_next         = phase_reg;
        header_count_next  = header_count_reg;
        type_next          = type_reg;
        length_next        = length_reg;
        value_count_next   = value_count_reg;
        value_accum_next   = value_accum_reg;
        error_code_next    = error_code_reg;
        pos_inc            = byte_position_reg + 32'd1;
        byte_position_next = pos_inc;
        value_count_inc    = value_count_reg + 32'd1;
        hdr_sel            = header_count_reg[1:0] - 2'd1;
        done               = 1'b0;
        emit               = 1'b0;
        result             = '0;

        // Take in the byte.
        if (phase_reg == PH_VALUE)
        begin
            // Value bytes beyond the eighth are counted but not stored.
            if (value_count_reg[31:3] == 29'd0)
            begin
                value_accum_next[{value_count_reg[2:0], 3'b000} +: 8] = data_byte;
            end
            value_count_next = value_count_inc;
            done = (value_count_inc == length_reg);
        end
        else if (phase_reg != PH_SKIP)
        begin
            if (header_count_reg == 3'd0)
            begin
                type_next = data_byte;
            end
            else
            begin
                length_next[{hdr_sel, 3'b000} +: 8] = data_byte;
            end
            header_count_next = header_count_reg + 3'd1;
            if (header_count_reg == 3'(HDR_BYTES - 1))
            begin
                header_count_next = 3'd0;
                value_count_next  = 32'd0;
                value_accum_next  = 64'd0;
                if (length_next == 32'd0)
                begin
                    done = 1'b1;
                end
                else
                begin
                    phase_next = PH_VALUE;
                end
            end
        end

        // Judge a completed record against its type rules and the limits.
        known = (type_next >= T_FANOUT) && (type_next <= T_LAST);
        priority if (!known)
        begin
            judge_st = cfg.strict_mode ? ST_UNKNOWN : ST_OK;
        end
        else if (type_next == T_GROUP)
        begin
            judge_st = (length_next > cfg.max_group_length) ? ST_LIMIT : ST_OK;
        end
        else if (length_next != {28'd0, need_len(type_next)})
        begin
            judge_st = ST_LEN;
        end
        else if (type_next == T_FANOUT && value_accum_next[31:0] > cfg.max_fanout)
        begin
            judge_st = ST_LIMIT;
        end
        else if (type_next == T_SAGA_STEP &&
                 value_accum_next[31:0] >= cfg.max_saga_steps)
        begin
            judge_st = ST_LIMIT;
        end
        else
        begin
            judge_st = ST_OK;
        end

        if (done)
        begin
            if (judge_st != ST_OK)
            begin
                error_code_next      = judge_st;
                phase_next           = PH_SKIP;
                result.record_type   = type_next;
                result.record_length = length_next;
                result.status        = judge_st;
                emit                 = 1'b1;
            end
            else
            begin
                phase_next = PH_HEADER;
                if (known)
                begin
                    result.record_valid  = 1'b1;
                    result.record_type   = type_next;
                    result.record_length = length_next;
                    if (type_next == T_GROUP)
                    begin
                        result.value_offset = pos_inc - length_next;
                    end
                    else
                    begin
                        result.record_value = value_accum_next;
                    end
                    emit = 1'b1;
                end
            end
            type_next        = 8'd0;
            length_next      = 32'd0;
            value_count_next = 32'd0;
            value_accum_next = 64'd0;
        end

        // End of section: settle the final status and return to reset state.
        if (last_byte)
        begin
            if (phase_next == PH_VALUE ||
                (phase_next == PH_HEADER && header_count_next != 3'd0))
            begin
                error_code_next = ST_TRUNC;
            end
            result.status      = error_code_next;
            result.section_end = 1'b1;
            emit               = 1'b1;
            phase_next         = PH_HEADER;
            header_count_next  = 3'd0;
            type_next          = 8'd0;
            length_next        = 32'd0;
            value_count_next   = 32'd0;
            value_accum_next   = 64'd0;
            byte_position_next = 32'd0;
            error_code_next    = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HEADER;
            header_count_reg  <= 3'd0;
            type_reg          <= 8'd0;
            length_reg        <= 32'd0;
            value_count_reg   <= 32'd0;
            value_accum_reg   <= 64'd0;
            byte_position_reg <= 32'd0;
            error_code_reg    <= ST_OK;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            header_count_reg  <= header_count_next;
            type_reg          <= type_next;
            length_reg        <= length_next;
            value_count_reg   <= value_count_next;
            value_accum_reg   <= value_accum_next;
            byte_position_reg <= byte_position_next;
            error_code_reg    <= error_code_next;
        end
    end

endmodule

`default_nettype wire

>>> src/tlv_section_parser.sv
// Channel   Direction  Handshake                 Payload
// -------   ---------  ------------------------  ---------------------------------------
// input     in         in_valid / in_stall       data_byte, last_byte
// output    out        out_valid / out_stall     record_valid .. section_end
// config    in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One section byte is taken per cycle while the input does not stall. A byte is
// held in the input register, and its result (if any) is registered into the
// output register when the byte moves on, at one byte per cycle without stalls.
// The input stalls only while the input register holds a byte and the output
// register holds a result that the output side is stalling.
// Reset returns the parser to the start of a section and the limits to their
// default values; configuration writes are always ready.
`default_nettype none

module tlv_section_parser (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [7:0]                         data_byte,
    input  wire logic                               last_byte,

    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic                                    record_valid,
    output logic [7:0]                              record_type,
    output logic [63:0]                             record_value,
    output logic [31:0]                             record_length,
    output logic [31:0]                             value_offset,
    output logic [2:0]                              status,
    output logic                                    section_end,

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [tlvsp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [31:0]                        cfg_data
);
    import tlvsp_pkg::*;

    cfg_t    cfg;
    result_t core_result;
    logic    core_emit;

    // Input register.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Output register.
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;

    logic in_accept;
    logic advance;

    // The byte in the input register moves on when the output register is
    // free or is being emptied in this cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    tlvsp_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tlvsp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .cfg       (cfg),
        .emit      (core_emit),
        .result    (core_result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && core_emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_byte;
        end
        if (advance && core_emit)
        begin
            out_reg <= core_result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign record_valid  = out_reg.record_valid;
    assign record_type   = out_reg.record_type;
    assign record_value  = out_reg.record_value;
    assign record_length = out_reg.record_length;
    assign value_offset  = out_reg.value_offset;
    assign status        = out_reg.status;
    assign section_end   = out_reg.section_end;

endmodule

`default_nettype wire
